// File: rtl/rwe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwe_pkg: shared types and constants of the recursive wind estimator
// Controller states, datapath commands and fixed-point limits.
// ----------------------------------------------------------------------------
package rwe_pkg;

  localparam logic signed [63:0] Lim31  = 64'sd2147483647;
  localparam logic signed [63:0] OneQ30 = 64'sd1073741824;
  localparam logic signed [63:0] OneQ16 = 64'sd65536;
  localparam logic [31:0] StartReset = 32'd20000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DIV,
    ST_OUT
  } state_e;

  // micro-op codes of the datapath sequence
  typedef enum logic [4:0] {
    OP_PREP,
    OP_MEANV0,
    OP_MEANV1,
    OP_SQ0,
    OP_SQ1,
    OP_MEANS,
    OP_PHI,
    OP_A0,
    OP_A1,
    OP_B0,
    OP_B1,
    OP_D,
    OP_C00,
    OP_C01,
    OP_C10,
    OP_C11,
    OP_G0,
    OP_G1,
    OP_PW,
    OP_W0,
    OP_W1,
    OP_DONE
  } op_e;

  typedef struct packed {
    logic start;
    logic accept;
    op_e  op;
    logic step;
    logic div_go;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic needs_div;
  } sts_t;

  function automatic logic signed [63:0] csym(input logic signed [63:0] v);
    logic signed [63:0] r;
    begin
      r = v;
      if (v > Lim31) r = Lim31;
      if (v < -Lim31) r = -Lim31;
      return r;
    end
  endfunction

  function automatic logic signed [63:0] c32(input logic signed [63:0] v);
    logic signed [63:0] r;
    begin
      r = v;
      if (v > Lim31) r = Lim31;
      if (v < -Lim31 - 64'sd1) r = -Lim31 - 64'sd1;
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/rwe_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwe_if: valid/ready channel carrying one word of payload
// Generic stream interface with source and sink views.
// ----------------------------------------------------------------------------
interface rwe_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/rwe_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwe_div: unsigned restoring divider
// 64-bit dividend by 64-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rwe_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        go_i,
  input  wire logic [63:0] num_i,
  input  wire logic [63:0] den_i,
  output logic             busy_o,
  output logic [63:0]      quo_o,
  output logic [63:0]      rem_o
);
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [64:0] trial;

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    trial = {rem_q, quo_q[63]} - {1'b0, den_q};
    if (go_i) begin
      cnt_d = 7'd64;
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != 7'd0) begin
      cnt_d = cnt_q - 7'd1;
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != 7'd0);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

// File: rtl/rwe_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwe_datapath: estimator state and arithmetic
// Holds means, gain matrix and wind; runs one micro-op phase per command.
// ----------------------------------------------------------------------------
module rwe_datapath #(
  parameter int VEL_WIDTH = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rwe_pkg::cmd_t               cmd_i,
  output rwe_pkg::sts_t                    sts_o,
  input  wire logic signed [VEL_WIDTH-1:0] vn_i,
  input  wire logic signed [VEL_WIDTH-1:0] ve_i,
  output logic signed [15:0]               wn_o,
  output logic signed [15:0]               we_o,
  output logic [31:0]                      cnt_o
);
  typedef logic signed [63:0] s64_t;

  s64_t mv_q [2];
  logic [47:0] ms_q;
  s64_t p_q [4];
  s64_t w_q [2];
  logic [31:0] cnt_q;
  s64_t x_q [2];
  s64_t phi_q [2];
  s64_t a_q [2];
  s64_t b_q [2];
  s64_t g_q [2];
  s64_t s_q, yv_q, d_q, pw_q, acc_q;
  logic [32:0] den_q;
  logic neg_q, phase_q;
  logic [63:0] q1_q;

  logic div_busy;
  logic [63:0] quo, rem;
  logic [63:0] dnum, dden;
  logic signed [31:0] m1a, m1b;
  s64_t mprod;
  s64_t diffv;
  logic [1:0] ci;

  assign mprod = m1a * m1b;

  rwe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.div_go),
    .num_i  (dnum),
    .den_i  (dden),
    .busy_o (div_busy),
    .quo_o  (quo),
    .rem_o  (rem)
  );

  always_comb begin
    ci = 2'd0;
    case (cmd_i.op)
      rwe_pkg::OP_C01: ci = 2'd1;
      rwe_pkg::OP_C10: ci = 2'd2;
      rwe_pkg::OP_C11: ci = 2'd3;
      default: ci = 2'd0;
    endcase
  end

  // multiplier operand selection
  always_comb begin
    m1a = '0;
    m1b = '0;
    case (cmd_i.op)
      rwe_pkg::OP_SQ0: begin m1a = 32'(x_q[0]); m1b = 32'(x_q[0]); end
      rwe_pkg::OP_SQ1: begin m1a = 32'(x_q[1]); m1b = 32'(x_q[1]); end
      rwe_pkg::OP_A0: begin
        m1a = phase_q ? 32'(p_q[1]) : 32'(p_q[0]);
        m1b = phase_q ? 32'(phi_q[1]) : 32'(phi_q[0]);
      end
      rwe_pkg::OP_A1: begin
        m1a = phase_q ? 32'(p_q[3]) : 32'(p_q[2]);
        m1b = phase_q ? 32'(phi_q[1]) : 32'(phi_q[0]);
      end
      rwe_pkg::OP_B0: begin
        m1a = phase_q ? 32'(p_q[2]) : 32'(p_q[0]);
        m1b = phase_q ? 32'(phi_q[1]) : 32'(phi_q[0]);
      end
      rwe_pkg::OP_B1: begin
        m1a = phase_q ? 32'(p_q[3]) : 32'(p_q[1]);
        m1b = phase_q ? 32'(phi_q[1]) : 32'(phi_q[0]);
      end
      rwe_pkg::OP_D: begin
        m1a = phase_q ? 32'(phi_q[1]) : 32'(phi_q[0]);
        m1b = phase_q ? 32'(a_q[1]) : 32'(a_q[0]);
      end
      rwe_pkg::OP_C00, rwe_pkg::OP_C01, rwe_pkg::OP_C10, rwe_pkg::OP_C11: begin
        m1a = 32'(a_q[ci[1]]); m1b = 32'(b_q[ci[0]]);
      end
      rwe_pkg::OP_G0: begin
        m1a = phase_q ? 32'((p_q[1] + p_q[2]) >>> 1) : 32'(p_q[0]);
        m1b = phase_q ? 32'(phi_q[1]) : 32'(phi_q[0]);
      end
      rwe_pkg::OP_G1: begin
        m1a = phase_q ? 32'(p_q[3]) : 32'((p_q[2] + p_q[1]) >>> 1);
        m1b = phase_q ? 32'(phi_q[1]) : 32'(phi_q[0]);
      end
      rwe_pkg::OP_PW: begin
        m1a = phase_q ? 32'(phi_q[1]) : 32'(phi_q[0]);
        m1b = phase_q ? 32'(w_q[1]) : 32'(w_q[0]);
      end
      rwe_pkg::OP_W0: begin m1a = 32'(g_q[0]); m1b = 32'(acc_q); end
      rwe_pkg::OP_W1: begin m1a = 32'(g_q[1]); m1b = 32'(acc_q); end
      default: begin m1a = '0; m1b = '0; end
    endcase
  end

  // divider operands: magnitude of floor-division numerator or gain product, or shifted remainder for the fraction
  always_comb begin
    diffv = '0;
    dnum = '0;
    dden = {31'd0, den_q};
    case (cmd_i.op)
      rwe_pkg::OP_MEANV0: diffv = x_q[0] - mv_q[0];
      rwe_pkg::OP_MEANV1: diffv = x_q[1] - mv_q[1];
      rwe_pkg::OP_MEANS:  diffv = s_q - s64_t'({16'd0, ms_q});
      default: diffv = '0;
    endcase
    if (cmd_i.op == rwe_pkg::OP_C00 || cmd_i.op == rwe_pkg::OP_C01 ||
        cmd_i.op == rwe_pkg::OP_C10 || cmd_i.op == rwe_pkg::OP_C11) begin
      dden = d_q;
      if (!phase_q) begin
        dnum = mprod[63] ? 64'(-mprod) : 64'(mprod);
      end else begin
        dnum = {rem[49:0], 14'd0};
      end
    end else begin
      dnum = diffv[63] ? 64'(-(diffv + 64'sd1)) : 64'(diffv);
    end
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.needs_div = 1'b0;

  logic signed [63:0] fq, corr;
  always_comb begin
    fq = neg_q ? -s64_t'(quo) - 64'sd1 : s64_t'(quo);
    if (q1_q >= 64'd131072) corr = 64'sd8589934592;
    else corr = s64_t'({q1_q[49:0], 14'd0}) + s64_t'(quo);
    if (neg_q) corr = -corr;
  end

  logic signed [63:0] vx_n, vx_e;
  assign vx_n = rwe_pkg::csym(64'(vn_i) * 64'sd256);
  assign vx_e = rwe_pkg::csym(64'(ve_i) * 64'sd256);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q[0] <= '0; mv_q[1] <= '0; ms_q <= '0;
      p_q[0] <= rwe_pkg::OneQ30; p_q[1] <= '0; p_q[2] <= '0; p_q[3] <= rwe_pkg::OneQ30;
      w_q[0] <= '0; w_q[1] <= '0; cnt_q <= '0; phase_q <= 1'b0;
    end else if (cmd_i.start && cmd_i.accept) begin
      if (cnt_q != 32'hFFFF_FFFF) begin
        cnt_q <= cnt_q + 32'd1;
        den_q <= {1'b0, cnt_q} + 33'd2;
      end else begin
        den_q <= {1'b0, cnt_q} + 33'd1;
      end
      x_q[0] <= vx_n;
      x_q[1] <= vx_e;
      phase_q <= 1'b0;
    end else if (cmd_i.step) begin
      case (cmd_i.op)
        rwe_pkg::OP_MEANV0: mv_q[0] <= mv_q[0] + fq;
        rwe_pkg::OP_MEANV1: mv_q[1] <= mv_q[1] + fq;
        rwe_pkg::OP_SQ0: s_q <= mprod >>> 16;
        rwe_pkg::OP_SQ1: s_q <= s_q + (mprod >>> 16);
        rwe_pkg::OP_MEANS: ms_q <= 48'(s64_t'({16'd0, ms_q}) + fq);
        rwe_pkg::OP_PHI: begin
          phi_q[0] <= rwe_pkg::csym(x_q[0] - mv_q[0]);
          phi_q[1] <= rwe_pkg::csym(x_q[1] - mv_q[1]);
          yv_q <= (s_q - s64_t'({16'd0, ms_q})) >>> 1;
        end
        rwe_pkg::OP_A0, rwe_pkg::OP_A1, rwe_pkg::OP_B0, rwe_pkg::OP_B1,
        rwe_pkg::OP_G0, rwe_pkg::OP_G1: begin
          if (!phase_q) begin
            acc_q <= mprod;
            phase_q <= 1'b1;
          end else begin
            phase_q <= 1'b0;
            case (cmd_i.op)
              rwe_pkg::OP_A0: a_q[0] <= rwe_pkg::csym((acc_q + mprod) >>> 30);
              rwe_pkg::OP_A1: a_q[1] <= rwe_pkg::csym((acc_q + mprod) >>> 30);
              rwe_pkg::OP_B0: b_q[0] <= rwe_pkg::csym((acc_q + mprod) >>> 30);
              rwe_pkg::OP_B1: b_q[1] <= rwe_pkg::csym((acc_q + mprod) >>> 30);
              rwe_pkg::OP_G0: g_q[0] <= rwe_pkg::csym((acc_q + mprod) >>> 30);
              default: g_q[1] <= rwe_pkg::csym((acc_q + mprod) >>> 30);
            endcase
          end
        end
        rwe_pkg::OP_D: begin
          if (!phase_q) begin
            acc_q <= mprod;
            phase_q <= 1'b1;
          end else begin
            phase_q <= 1'b0;
            d_q <= (rwe_pkg::OneQ16 + ((acc_q + mprod) >>> 16)) < 64'sd1 ? 64'sd1 :
                   rwe_pkg::OneQ16 + ((acc_q + mprod) >>> 16);
          end
        end
        rwe_pkg::OP_C00, rwe_pkg::OP_C01, rwe_pkg::OP_C10, rwe_pkg::OP_C11: begin
          if (!phase_q) begin
            neg_q <= mprod[63];
            phase_q <= 1'b1;
          end else begin
            phase_q <= 1'b0;
            p_q[ci] <= rwe_pkg::c32(p_q[ci] - corr);
          end
        end
        rwe_pkg::OP_PW: begin
          if (!phase_q) begin
            acc_q <= mprod;
            phase_q <= 1'b1;
          end else begin
            phase_q <= 1'b0;
            acc_q <= rwe_pkg::csym(yv_q - ((acc_q + mprod) >>> 16));
          end
        end
        rwe_pkg::OP_W0: w_q[0] <= rwe_pkg::c32(w_q[0] + (mprod >>> 16));
        rwe_pkg::OP_W1: w_q[1] <= rwe_pkg::c32(w_q[1] + (mprod >>> 16));
        default: ;
      endcase
    end else if (cmd_i.div_go) begin
      if (cmd_i.op == rwe_pkg::OP_MEANV0 || cmd_i.op == rwe_pkg::OP_MEANV1 ||
          cmd_i.op == rwe_pkg::OP_MEANS) begin
        neg_q <= diffv[63];
      end else if (phase_q) begin
        q1_q <= quo;
      end
    end
  end

  function automatic logic signed [15:0] sat16(input s64_t v);
    s64_t t;
    begin
      t = v >>> 8;
      if (t > 64'sd32767) return 16'sh7FFF;
      if (t < -64'sd32768) return 16'sh8000;
      return t[15:0];
    end
  endfunction

  assign wn_o  = sat16(w_q[0]);
  assign we_o  = sat16(w_q[1]);
  assign cnt_o = cnt_q;
endmodule
`default_nettype wire

// File: rtl/rwe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwe_ctrl: estimator sequencer
// Steps the datapath through its micro-ops and handles the handshakes.
// ----------------------------------------------------------------------------
module rwe_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          acc_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rwe_pkg::cmd_t      cmd_o,
  input  wire rwe_pkg::sts_t sts_i,
  output logic               load_o
);
  rwe_pkg::state_e st_q, st_d;
  rwe_pkg::op_e    op_q, op_d;
  logic            ph_q, ph_d;
  logic            isdiv, twoph, isc;

  always_comb begin
    isc = (op_q == rwe_pkg::OP_C00 || op_q == rwe_pkg::OP_C01 ||
           op_q == rwe_pkg::OP_C10 || op_q == rwe_pkg::OP_C11);
    isdiv = isc || op_q == rwe_pkg::OP_MEANV0 || op_q == rwe_pkg::OP_MEANV1 ||
            op_q == rwe_pkg::OP_MEANS;
    twoph = !isdiv && (op_q == rwe_pkg::OP_A0 || op_q == rwe_pkg::OP_A1 ||
            op_q == rwe_pkg::OP_B0 || op_q == rwe_pkg::OP_B1 ||
            op_q == rwe_pkg::OP_D || op_q == rwe_pkg::OP_G0 ||
            op_q == rwe_pkg::OP_G1 || op_q == rwe_pkg::OP_PW);
  end

  // next state
  always_comb begin
    st_d = st_q;
    op_d = op_q;
    ph_d = ph_q;
    case (st_q)
      rwe_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          ph_d = 1'b0;
          op_d = rwe_pkg::OP_MEANV0;
          st_d = acc_i ? rwe_pkg::ST_DIV : rwe_pkg::ST_OUT;
        end
      end
      rwe_pkg::ST_DIV: begin
        // divider launch; C ops launch twice (quotient then fraction)
        st_d = rwe_pkg::ST_RUN;
      end
      rwe_pkg::ST_RUN: begin
        if (isdiv) begin
          if (!sts_i.div_busy) begin
            if (isc && !ph_q) begin
              ph_d = 1'b1;
              st_d = rwe_pkg::ST_DIV;
            end else begin
              ph_d = 1'b0;
              op_d = rwe_pkg::op_e'(op_q + 5'd1);
              st_d = (op_q == rwe_pkg::OP_MEANS || op_q == rwe_pkg::OP_MEANV0 ||
                      op_q == rwe_pkg::OP_C00 || op_q == rwe_pkg::OP_C01 ||
                      op_q == rwe_pkg::OP_C10) &&
                     (op_d == rwe_pkg::OP_MEANV1 || op_d == rwe_pkg::OP_C01 ||
                      op_d == rwe_pkg::OP_C10 || op_d == rwe_pkg::OP_C11) ?
                     rwe_pkg::ST_DIV : rwe_pkg::ST_RUN;
            end
          end
        end else if (twoph && !ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          op_d = rwe_pkg::op_e'(op_q + 5'd1);
          if (op_q == rwe_pkg::OP_SQ1 || op_q == rwe_pkg::OP_D) st_d = rwe_pkg::ST_DIV;
          if (op_q == rwe_pkg::OP_W1) st_d = rwe_pkg::ST_OUT;
        end
      end
      rwe_pkg::ST_OUT: begin
        if (out_ready_i) st_d = rwe_pkg::ST_IDLE;
      end
      default: st_d = rwe_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.start  = (st_q == rwe_pkg::ST_IDLE) && in_valid_i;
    cmd_o.accept = acc_i;
    cmd_o.op     = op_q;
    cmd_o.div_go = (st_q == rwe_pkg::ST_DIV);
    cmd_o.step   = 1'b0;
    if (st_q == rwe_pkg::ST_RUN) begin
      if (isdiv) cmd_o.step = !sts_i.div_busy && (!isc || ph_q);
      else cmd_o.step = 1'b1;
    end
    if (st_q == rwe_pkg::ST_RUN && isc && !ph_q && !sts_i.div_busy) cmd_o.step = 1'b1;
    in_ready_o  = (st_q == rwe_pkg::ST_IDLE);
    out_valid_o = (st_q == rwe_pkg::ST_OUT);
    load_o      = cmd_o.start;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= rwe_pkg::ST_IDLE;
      op_q <= rwe_pkg::OP_MEANV0;
      ph_q <= 1'b0;
    end else begin
      st_q <= st_d;
      op_q <= op_d;
      ph_q <= ph_d;
    end
  end
endmodule
`default_nettype wire

// File: rtl/recursive_wind_estimator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// recursive_wind_estimator_top: 2D recursive least-squares wind estimator
// Updates means, gain matrix and wind from each accepted ground-velocity word.
// ----------------------------------------------------------------------------
//   channel  dir  payload
//   cfg      in   start_time_ms
//   in       in   time_ms, vel_north, vel_east, last_sample
//   out      out  wind_north, wind_east, samples_used, accepted, final_res
// A used word makes eleven passes through the shared one-bit-per-cycle
// 64-bit divider; a rejected word goes straight to the out channel.
// One word is in flight at a time; in.ready is low until out is taken.
// Reset gives identity gain, zero wind and start_time_ms 20000.
// ----------------------------------------------------------------------------
module recursive_wind_estimator_top #(
  parameter int VEL_WIDTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rwe_if.sink       cfg,
  rwe_if.sink       in,
  rwe_if.source     out
);
  logic [31:0] start_q;
  logic        acc_q, last_q;
  logic        load;
  logic        in_ready, out_valid;
  rwe_pkg::cmd_t cmd;
  rwe_pkg::sts_t sts;
  logic signed [15:0] wn, we;
  logic [31:0] cnt;
  logic acc_now;

  assign cfg.ready = 1'b1;
  assign acc_now = in.data.time_ms >= start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= rwe_pkg::StartReset;
      acc_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      if (cfg.valid) start_q <= cfg.data;
      if (load) begin
        acc_q <= acc_now;
        last_q <= in.data.last_sample;
      end
    end
  end

  rwe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in.valid),
    .in_ready_o  (in_ready),
    .acc_i       (acc_now),
    .out_valid_o (out_valid),
    .out_ready_i (out.ready),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .load_o      (load)
  );

  rwe_datapath #(.VEL_WIDTH(VEL_WIDTH)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .vn_i   (in.data.vel_north),
    .ve_i   (in.data.vel_east),
    .wn_o   (wn),
    .we_o   (we),
    .cnt_o  (cnt)
  );

  assign in.ready = in_ready;
  assign out.valid = out_valid;
  assign out.data.wind_north = wn;
  assign out.data.wind_east = we;
  assign out.data.samples_used = cnt;
  assign out.data.accepted = acc_q;
  assign out.data.final_res = last_q;
endmodule
`default_nettype wire

// File: dv/tb_recursive_wind_estimator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_recursive_wind_estimator_top: self-checking bench of the wind estimator
// Drives ground-velocity words through several start-time settings with
// random gaps on both sides, predicts each wind word in fixed point and
// compares every field of every result in order.
// ----------------------------------------------------------------------------
module tb_recursive_wind_estimator_top;

  localparam int VEL_WIDTH = 16;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef struct packed {
    logic [31:0]                  time_ms;
    logic signed [VEL_WIDTH-1:0]  vel_north;
    logic signed [VEL_WIDTH-1:0]  vel_east;
    logic                         last_sample;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] wind_north;
    logic signed [15:0] wind_east;
    logic [31:0]        samples_used;
    logic               accepted;
    logic               final_res;
  } wind_t;

  class wind_scoreboard;
    logic [31:0] start_ms;
    longint      mean_v[2];
    longint      mean_sq;
    longint      gain[4];
    longint      wind[2];
    logic [31:0] count;
    wind_t       pending[$];
    int          errors;
    int          used;
    int          rejected;

    function new();
      start_ms = rwe_pkg::StartReset;
      mean_v = '{0, 0};
      mean_sq = 0;
      gain = '{64'sd1 << 30, 0, 0, 64'sd1 << 30};
      wind = '{0, 0};
      count = 0;
      errors = 0;
      used = 0;
      rejected = 0;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint sym_clip(longint v);
      return clip(v, -64'sd2147483647, 64'sd2147483647);
    endfunction

    function longint floor_div(longint num, longint den);
      if (num >= 0) return num / den;
      return -((-(num + 1)) / den) - 1;
    endfunction

    function longint gain_step(longint a, longint b, longint d);
      longint prod;
      longint unsigned mag, q, r, res;
      prod = a * b;
      mag = prod < 0 ? longint'(-prod) : prod;
      q = mag / longint'(d);
      r = mag % longint'(d);
      if (q >= (64'd1 << 17)) res = 64'd1 << 33;
      else res = (q << 14) + ((r << 14) / longint'(d));
      return prod < 0 ? -longint'(res) : longint'(res);
    endfunction

    function void note_sample(sample_t s);
      longint x[2], phi[2], a[2], b[2], g[2];
      longint sq, yv, e, d, pw, den, s0, s1;
      wind_t w;
      w.accepted = s.time_ms >= start_ms;
      if (w.accepted) begin
        used++;
        if (count != 32'hFFFF_FFFF) count++;
        den = longint'(count) + 1;
        x[0] = sym_clip(longint'(s.vel_north) * 256);
        x[1] = sym_clip(longint'(s.vel_east) * 256);
        for (int i = 0; i < 2; i++) mean_v[i] += floor_div(x[i] - mean_v[i], den);
        sq = ((x[0] * x[0]) >>> 16) + ((x[1] * x[1]) >>> 16);
        mean_sq += floor_div(sq - mean_sq, den);
        for (int i = 0; i < 2; i++) phi[i] = sym_clip(x[i] - mean_v[i]);
        yv = (sq - mean_sq) >>> 1;
        for (int i = 0; i < 2; i++) begin
          a[i] = sym_clip((gain[i*2] * phi[0] + gain[i*2+1] * phi[1]) >>> 30);
          b[i] = sym_clip((gain[i] * phi[0] + gain[2+i] * phi[1]) >>> 30);
        end
        d = 65536 + ((phi[0] * a[0] + phi[1] * a[1]) >>> 16);
        if (d < 1) d = 1;
        for (int i = 0; i < 2; i++)
          for (int j = 0; j < 2; j++)
            gain[i*2+j] = clip(gain[i*2+j] - gain_step(a[i], b[j], d),
                               -64'sd2147483648, 64'sd2147483647);
        for (int i = 0; i < 2; i++) begin
          s0 = (gain[i*2] + gain[i]) >>> 1;
          s1 = (gain[i*2+1] + gain[2+i]) >>> 1;
          g[i] = sym_clip((s0 * phi[0] + s1 * phi[1]) >>> 30);
        end
        pw = (phi[0] * wind[0] + phi[1] * wind[1]) >>> 16;
        e = sym_clip(yv - pw);
        for (int i = 0; i < 2; i++)
          wind[i] = clip(wind[i] + ((g[i] * e) >>> 16),
                         -64'sd2147483648, 64'sd2147483647);
      end else begin
        rejected++;
      end
      w.wind_north = 16'(clip(wind[0] >>> 8, -32768, 32767));
      w.wind_east = 16'(clip(wind[1] >>> 8, -32768, 32767));
      w.samples_used = count;
      w.final_res = s.last_sample;
      pending.push_back(w);
    endfunction

    function void check_result(wind_t got);
      wind_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.wind_north !== want.wind_north)
        $display("%0t: wind_north exp %0d got %0d", $time, want.wind_north, got.wind_north);
      if (got.wind_east !== want.wind_east)
        $display("%0t: wind_east exp %0d got %0d", $time, want.wind_east, got.wind_east);
      if (got.samples_used !== want.samples_used)
        $display("%0t: samples_used exp %0d got %0d", $time, want.samples_used,
                 got.samples_used);
      if (got.accepted !== want.accepted)
        $display("%0t: accepted exp %0b got %0b", $time, want.accepted, got.accepted);
      if (got.final_res !== want.final_res)
        $display("%0t: final_res exp %0b got %0b", $time, want.final_res, got.final_res);
      if (got !== want) errors++;
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni;
  longint cycles;
  bit     quiet;
  wind_scoreboard sb;

  rwe_if #(.T(logic [31:0])) cfg_bus ();
  rwe_if #(.T(sample_t))     in_bus ();
  rwe_if #(.T(wind_t))       out_bus ();

  recursive_wind_estimator_top #(.VEL_WIDTH(VEL_WIDTH)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg   (cfg_bus),
    .in    (in_bus),
    .out   (out_bus)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) sb.check_result(out_bus.data);
  end

  // result side: random stall before each word
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = quiet ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_bus.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_bus.ready = 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
    end
  end

  task automatic send_sample(input sample_t s);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    @(negedge clk_i);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.data = s;
    in_bus.valid = 1'b1;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_sample(s);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_bus.valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_start(input logic [31:0] value);
    drain();
    @(negedge clk_i);
    cfg_bus.data = value;
    cfg_bus.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_bus.ready);
    sb.start_ms = value;
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  function automatic sample_t make_sample(input logic [31:0] start, input bit late);
    sample_t s;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (late || start == 0) s.time_ms = start + $urandom_range(0, ~start);
    else s.time_ms = $urandom_range(0, start - 1);
    if (pick < 6) begin
      s.vel_north = VEL_WIDTH'($urandom_range(0, 4000)) - VEL_WIDTH'(2000);
      s.vel_east = VEL_WIDTH'($urandom_range(0, 4000)) - VEL_WIDTH'(2000);
    end else begin
      s.vel_north = VEL_WIDTH'($urandom);
      s.vel_east = VEL_WIDTH'($urandom);
    end
    s.last_sample = ($urandom_range(0, 15) == 0);
    return s;
  endfunction

  task automatic run_phase(input int items);
    for (int k = 0; k < items; k++) begin
      if (k == items / 2) drain();
      send_sample(make_sample(sb.start_ms, $urandom_range(0, 3) != 0));
    end
  endtask

  initial begin
    logic [31:0] settings[6];
    sb = new();
    cycles = 0;
    quiet = 1'b0;
    rst_ni = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    in_bus.valid = 1'b0;
    in_bus.data = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: window edges, velocity extremes, end marker
    send_sample('{32'd0, 16'sd1000, -16'sd1000, 1'b0});
    send_sample('{32'd19999, 16'sd32767, 16'sd32767, 1'b1});
    send_sample('{32'd20000, 16'sd0, 16'sd0, 1'b0});
    send_sample('{32'd20001, 16'sd32767, 16'sd32767, 1'b0});
    send_sample('{32'd20002, -16'sd32768, -16'sd32768, 1'b0});
    send_sample('{32'd20003, 16'sd32767, -16'sd32768, 1'b1});
    send_sample('{32'd20004, -16'sd32768, 16'sd32767, 1'b0});
    send_sample('{32'hFFFF_FFFF, 16'sd256, -16'sd256, 1'b0});
    send_sample('{32'd20005, 16'sd1, -16'sd1, 1'b0});
    send_sample('{32'd20006, 16'sd0, 16'sd32767, 1'b0});
    send_sample('{32'd20007, -16'sd32768, 16'sd0, 1'b1});
    send_sample('{32'd5, -16'sd32768, 16'sd32767, 1'b0});
    send_sample('{32'd30000, 16'sd512, 16'sd768, 1'b0});
    quiet = 1'b1;
    run_phase(150);
    quiet = 1'b0;

    settings = '{32'd0, 32'hFFFF_FFFF, 32'd1000, $urandom, 32'h8000_0000, 32'd0};
    foreach (settings[p]) begin
      write_start(settings[p]);
      if (settings[p] == 32'hFFFF_FFFF) begin
        send_sample('{32'hFFFF_FFFE, 16'sd100, 16'sd100, 1'b0});
        send_sample('{32'hFFFF_FFFF, -16'sd100, 16'sd300, 1'b1});
      end
      quiet = (p == 2);
      run_phase(280);
      quiet = 1'b0;
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("Run covered %0d used and %0d ignored words over %0d start-time settings.",
             sb.used, sb.rejected, 7);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
